@@ src/cbbs_pkg.sv @@
// Shared types, constants and helpers for the code block boundary splitter.
// No dependencies; imported by cbbs_scan and code_block_boundary_splitter.
package cbbs_pkg;

    // Offset counter, brace depth and output widths
    localparam int OFFSET_BITS = 32;
    localparam int DEPTH_BITS  = 16;
    localparam int OUT_BITS    = 32;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       doc_end;
    } in_item_t;

    // One result request
    typedef struct packed {
        logic [OUT_BITS-1:0] span_begin;
        logic [OUT_BITS-1:0] span_finish;
        logic                closes_document;
        logic                offset_overflow;
    } out_item_t;

    // Byte handed from the top level to the scanner
    typedef struct packed {
        logic       take;
        logic [7:0] data_byte;
        logic       doc_end;
    } scan_req_t;

    // Mask or zero-extend an offset to the output width
    function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_BITS-1:0] w;
        begin
            w = {{OUT_BITS{1'b0}}, v};
            return w[OUT_BITS-1:0];
        end
    endfunction

endpackage

@@ src/cbbs_scan.sv @@
// Lexical scanner: strings, char literals, escapes, comments, brace depth
// and blank-line tracking. Depends on cbbs_pkg.
module cbbs_scan
    import cbbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  scan_req_t req,
    output logic      line_closes
);

    logic [DEPTH_BITS-1:0] level_reg, level_next;
    logic in_str_reg, in_str_next;
    logic in_chr_reg, in_chr_next;
    logic esc_reg, esc_next;
    logic lcmt_reg, lcmt_next;
    logic bcmt_reg, bcmt_next;
    logic slash_reg, slash_next;
    logic star_reg, star_next;
    logic blank_reg, blank_next;

    logic [7:0] c;

    assign c = req.data_byte;

    // A newline now would close a unit
    assign line_closes = blank_reg && (level_reg == '0);

    // Next-state logic for one byte
    always_comb begin
        level_next  = level_reg;
        in_str_next = in_str_reg;
        in_chr_next = in_chr_reg;
        esc_next    = esc_reg;
        lcmt_next   = lcmt_reg;
        bcmt_next   = bcmt_reg;
        slash_next  = slash_reg;
        star_next   = star_reg;
        blank_next  = blank_reg;
        if (c == CH_NL) begin
            slash_next = 1'b0;
            lcmt_next  = 1'b0;
            star_next  = 1'b0;
            blank_next = 1'b1;
        end else begin
            if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
                blank_next = 1'b0;
            end
            star_next = (c == CH_STAR);
            if (lcmt_reg) begin
                // line comment swallows everything
            end else if (bcmt_reg) begin
                if (c == CH_SLASH && star_reg) begin
                    bcmt_next = 1'b0;
                end
            end else if (in_str_reg || in_chr_reg) begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (in_str_reg && c == CH_DQUOTE) begin
                    in_str_next = 1'b0;
                end else if (in_chr_reg && c == CH_SQUOTE) begin
                    in_chr_next = 1'b0;
                end
            end else if (slash_reg && c == CH_SLASH) begin
                slash_next = 1'b0;
                lcmt_next  = 1'b1;
            end else if (slash_reg && c == CH_STAR) begin
                slash_next = 1'b0;
                bcmt_next  = 1'b1;
            end else begin
                slash_next = 1'b0;
                if (c == CH_DQUOTE) begin
                    in_str_next = 1'b1;
                end else if (c == CH_SQUOTE) begin
                    in_chr_next = 1'b1;
                end else if (c == CH_SLASH) begin
                    slash_next = 1'b1;
                end else if (c == CH_LBRACE) begin
                    if (level_reg != '1) begin
                        level_next = level_reg + 1'b1;
                    end
                end else if (c == CH_RBRACE) begin
                    if (level_reg != '0) begin
                        level_next = level_reg - 1'b1;
                    end
                end
            end
        end
    end

    // State registers; the last byte of a document returns to reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (req.take && req.doc_end)) begin
            level_reg  <= '0;
            in_str_reg <= 1'b0;
            in_chr_reg <= 1'b0;
            esc_reg    <= 1'b0;
            lcmt_reg   <= 1'b0;
            bcmt_reg   <= 1'b0;
            slash_reg  <= 1'b0;
            star_reg   <= 1'b0;
            blank_reg  <= 1'b1;
        end else if (req.take) begin
            level_reg  <= level_next;
            in_str_reg <= in_str_next;
            in_chr_reg <= in_chr_next;
            esc_reg    <= esc_next;
            lcmt_reg   <= lcmt_next;
            bcmt_reg   <= bcmt_next;
            slash_reg  <= slash_next;
            star_reg   <= star_next;
            blank_reg  <= blank_next;
        end
    end

endmodule

@@ src/code_block_boundary_splitter.sv @@
// Top level of the code block boundary splitter: offset tracking, span
// emission and the result register. Depends on cbbs_pkg and cbbs_scan.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | s_valid, s_ready, s_payload    | in_item_t  (byte, doc_end)
//  result  | m_valid, m_ready, m_payload    | out_item_t (span, flags)
//
// One byte per clock; a byte's scan and span decision finish in the cycle
// it is taken, and its result (if any) appears in the result register the
// cycle after. A held result stalls input only while m_ready is low.
// aresetn is synchronous, active low, and clears all scan and offset state;
// the last byte of a document does the same after its result is formed.
module code_block_boundary_splitter
    import cbbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   m_valid_reg;
    out_item_t              m_payload_reg;

    logic                   take;
    logic                   is_nl;
    logic                   line_closes;
    logic                   emit;
    logic [OFFSET_BITS-1:0] span_b;
    logic [OFFSET_BITS-1:0] span_f;
    scan_req_t              scan_req;

    // Accept whenever the result slot is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign scan_req.take      = take;
    assign scan_req.data_byte = s_payload.data_byte;
    assign scan_req.doc_end   = s_payload.doc_end;

    cbbs_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (scan_req),
        .line_closes (line_closes)
    );

    // Saturating offset counter
    always_comb begin
        if (pos_reg == '1) begin
            pos_next = pos_reg;
            ovf_next = 1'b1;
        end else begin
            pos_next = pos_reg + 1'b1;
            ovf_next = ovf_reg;
        end
    end

    // Span selection: a closing blank line ends before its newline,
    // otherwise the last byte ends the remainder after itself
    assign is_nl  = (s_payload.data_byte == CH_NL);
    assign span_b = start_reg;
    assign span_f = (is_nl && line_closes) ? pos_reg : pos_next;
    assign emit   = ((is_nl && line_closes) || s_payload.doc_end) && (span_f > span_b);

    // Offset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_payload.doc_end)) begin
            pos_reg   <= '0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (take) begin
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
            if (is_nl && line_closes) begin
                start_reg <= pos_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            m_payload_reg.span_begin      <= to_out(span_b);
            m_payload_reg.span_finish     <= to_out(span_f);
            m_payload_reg.closes_document <= s_payload.doc_end;
            m_payload_reg.offset_overflow <= ovf_next;
        end
    end

endmodule

@@ verif/code_block_boundary_splitter_test.sv @@
// Self-checking testbench for code_block_boundary_splitter: drives source-text bytes,
// predicts the emitted unit spans and checks every result request field by field.
// Depends on cbbs_pkg and the splitter RTL.
module code_block_boundary_splitter_test
    import cbbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        in_item_t req;
        bit       steady;   // sent back to back, no gap before the next one
    } queued_byte_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    queued_byte_t byte_queue[$];
    out_item_t    expected_spans[$];
    queued_byte_t next_req;
    out_item_t    want;

    int bytes_queued = 0;
    int bytes_sent = 0;
    int bytes_taken = 0;
    int spans_checked = 0;
    int mismatches = 0;
    int idle_left = 0;
    int hold_left = 0;
    int ready_cycles = 0;
    bit long_hold_done = 1'b0;

    // Scanner state mirrored from the block
    logic [OFFSET_BITS-1:0] doc_pos = '0;
    logic [OFFSET_BITS-1:0] unit_start = '0;
    logic [DEPTH_BITS-1:0]  depth = '0;
    logic in_str = 1'b0;
    logic in_chr = 1'b0;
    logic esc_wait = 1'b0;
    logic in_line_cmt = 1'b0;
    logic in_block_cmt = 1'b0;
    logic slash_wait = 1'b0;
    logic star_prev = 1'b0;
    logic blank_line = 1'b1;
    logic ovf_seen = 1'b0;

    code_block_boundary_splitter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_doc();
        doc_pos = '0;
        unit_start = '0;
        depth = '0;
        in_str = 1'b0;
        in_chr = 1'b0;
        esc_wait = 1'b0;
        in_line_cmt = 1'b0;
        in_block_cmt = 1'b0;
        slash_wait = 1'b0;
        star_prev = 1'b0;
        blank_line = 1'b1;
        ovf_seen = 1'b0;
    endfunction

    // Zero-length spans are dropped
    function automatic void emit_span(input logic [OFFSET_BITS-1:0] b,
                                      input logic [OFFSET_BITS-1:0] f, input logic last);
        out_item_t span;
        if (f > b) begin
            span.span_begin = b;
            span.span_finish = f;
            span.closes_document = last;
            span.offset_overflow = ovf_seen;
            expected_spans.insert(expected_spans.size(), span);
        end
    endfunction

    // Lexical tracking of one non-newline byte: strings, literals, comments, braces
    function automatic void lex_byte(input logic [7:0] c);
        if (in_line_cmt) begin
            return;
        end
        if (in_block_cmt) begin
            if (c == CH_SLASH && star_prev) in_block_cmt = 1'b0;
            return;
        end
        if (in_str || in_chr) begin
            if (esc_wait) esc_wait = 1'b0;
            else if (c == CH_BSLASH) esc_wait = 1'b1;
            else if (in_str && c == CH_DQUOTE) in_str = 1'b0;
            else if (in_chr && c == CH_SQUOTE) in_chr = 1'b0;
            return;
        end
        // one-byte lookahead after a slash
        if (slash_wait) begin
            slash_wait = 1'b0;
            if (c == CH_SLASH) begin
                in_line_cmt = 1'b1;
                return;
            end
            if (c == CH_STAR) begin
                in_block_cmt = 1'b1;
                return;
            end
        end
        case (c)
            CH_DQUOTE: in_str = 1'b1;
            CH_SQUOTE: in_chr = 1'b1;
            CH_SLASH:  slash_wait = 1'b1;
            CH_LBRACE: begin
                if (depth != '1) depth = depth + 1'b1;
            end
            CH_RBRACE: begin
                if (depth != '0) depth = depth - 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Advance the mirror by one accepted byte and queue the span it closes, if any
    function automatic void split_byte(input in_item_t req);
        logic [7:0]             c;
        logic                   last;
        logic                   closes;
        logic [OFFSET_BITS-1:0] here;
        logic [OFFSET_BITS-1:0] ahead;
        c = req.data_byte;
        last = req.doc_end;
        here = doc_pos;
        if (here == '1) begin
            ahead = '1;
            ovf_seen = 1'b1;
        end else begin
            ahead = here + 1'b1;
        end
        if (c == CH_NL) begin
            closes = blank_line && depth == '0;
            slash_wait = 1'b0;
            in_line_cmt = 1'b0;
            star_prev = 1'b0;
            blank_line = 1'b1;
            if (closes) begin
                emit_span(unit_start, here, last);
                unit_start = ahead;
            end else if (last) begin
                emit_span(unit_start, ahead, 1'b1);
            end
        end else begin
            if (c != CH_SPACE && c != CH_TAB && c != CH_CR) blank_line = 1'b0;
            lex_byte(c);
            star_prev = (c == CH_STAR);
            if (last) emit_span(unit_start, ahead, 1'b1);
        end
        doc_pos = ahead;
        if (last) clear_doc();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input bit steady = 1'b0);
        queued_byte_t q;
        q.req.data_byte = b;
        q.req.doc_end = last;
        q.steady = steady;
        byte_queue.insert(byte_queue.size(), q);
    endtask

    task automatic push_text(input string s, input bit steady = 1'b0);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], 1'b0, steady);
        end
    endtask

    // Code-like fragments; balanced braces and blank lines so units close often
    task automatic add_fragment();
        case ($urandom_range(0, 19))
            0, 1: push_text("\n");
            2:  push_text(" \t\015\n");
            3:  push_text("x = y;\n");
            4:  push_text("{");
            5:  push_text("}");
            6:  push_text("}}\n");
            7:  push_text("f() {\n");
            8:  push_text("\"s{\\\"}\\\\\"");
            9:  push_text("'\\''");
            10: push_text("'{'");
            11: push_text("// note {\n");
            12: push_text("/* { */");
            13: push_text("/*/ } */");
            14: push_text("a / b");
            15: push_text("/\n*");
            16: push_text("*/");
            17: push_byte(8'($urandom_range(0, 255)), 1'b0);
            18: push_text("\"\n{\n\"");
            default: push_text("\n\n");
        endcase
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                split_byte(s_payload);
                bytes_taken++;
            end
            if (!(s_valid && !s_ready)) begin
                if (idle_left != 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    next_req = byte_queue.pop_front();
                    s_valid <= 1'b1;
                    s_payload <= next_req.req;
                    idle_left = (next_req.steady || bytes_sent[8:7] == 2'b00) ? 0 : pick_gap();
                    bytes_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure: random stalls, quiet stretches, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            ready_cycles++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && m_valid && spans_checked >= 20) begin
                long_hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (ready_cycles[9:8] != 2'b00 && $urandom_range(0, 3) == 0) begin
                    hold_left = pick_gap();
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time, m_payload);
                mismatches++;
            end else begin
                want = expected_spans.pop_front();
                check_field("span_begin", 64'(want.span_begin), 64'(m_payload.span_begin));
                check_field("span_finish", 64'(want.span_finish),
                            64'(m_payload.span_finish));
                check_field("closes_document", 64'(want.closes_document),
                            64'(m_payload.closes_document));
                check_field("offset_overflow", 64'(want.offset_overflow),
                            64'(m_payload.offset_overflow));
            end
            spans_checked++;
        end
    end

    // Stimulus and end of run
    initial begin
        int random_start;

        // single byte document at the top code, then a lone newline (empty unit)
        push_byte(8'hFF, 1'b1);
        push_byte(CH_NL, 1'b1);
        // blank line as last byte closes; an unclosed line runs through its newline
        push_text("x\n");
        push_byte(CH_NL, 1'b1);
        push_text("{");
        push_byte(CH_NL, 1'b1);
        // slash-star-slash is a whole comment; a line comment hides its brace
        push_text("/*/\n\n");
        push_byte(8'h00, 1'b1);
        push_text("//{\n\n");
        push_byte(8'h61, 1'b1);

        // Random documents built from code fragments and noise bytes
        random_start = byte_queue.size();
        while (byte_queue.size() - random_start < 1250) begin
            repeat ($urandom_range(1, 30)) add_fragment();
            if ($urandom_range(0, 1) != 0) begin
                push_byte(CH_NL, 1'b1);
            end else begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        bytes_queued = byte_queue.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken != bytes_queued) @(posedge aclk);
        while (expected_spans.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
